/* src/insertion_sorter_macros.svh */
// Assertion macros shared by the insertion sorter modules.
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ISRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/isrt_pkg.sv */
// Types shared by the insertion sorter controller, datapath and top level.
package isrt_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               last_res;
    logic               overflow;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic ld_item;   // capture input item, p <= count
    logic rd_k;      // read address k (else insertion read address)
    logic shift;     // store[p] <= read data, p <= p - 1
    logic wr_v;      // store[p] <= held value
    logic cnt_inc;
    logic cnt_clr;
    logic fl_start;  // k <= 0, overflow flag <= fl_ovf
    logic fl_ovf;
    logic ld_out;    // load output register from read data
    logic k_inc;
  } isrt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic full;
    logic p_zero;
    logic p_one;
    logic less;
    logic k_last;
    logic out_taken;
    logic last_held;
  } isrt_sts_t;

endpackage

/* src/isrt_ctrl.sv */
// Insertion sorter controller: sequences insertion and flush.
module isrt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  isrt_pkg::isrt_sts_t sts,
  output isrt_pkg::isrt_cmd_t cmd
);
  import isrt_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_RD  = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_FL_RD   = 3'd3;
  localparam logic [2:0] ST_FL_LD   = 3'd4;
  localparam logic [2:0] ST_FL_WAIT = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          if (sts.full) begin
            // drop the item and flush with overflow
            cmd.fl_start = 1'b1;
            cmd.fl_ovf   = 1'b1;
            state_nxt    = ST_FL_RD;
          end else begin
            state_nxt = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (sts.p_zero) begin
          cmd.wr_v    = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (sts.last_held) begin
            cmd.fl_start = 1'b1;
            state_nxt    = ST_FL_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts.less) begin
          cmd.shift = 1'b1;
          if (sts.p_one) begin
            state_nxt = ST_INS_RD;
          end
        end else begin
          cmd.wr_v    = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (sts.last_held) begin
            cmd.fl_start = 1'b1;
            state_nxt    = ST_FL_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FL_RD: begin
        cmd.rd_k  = 1'b1;
        state_nxt = ST_FL_LD;
      end
      ST_FL_LD: begin
        cmd.ld_out = 1'b1;
        state_nxt  = ST_FL_WAIT;
      end
      ST_FL_WAIT: begin
        if (sts.out_taken) begin
          if (sts.k_last) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = ST_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`include "insertion_sorter_macros.svh"

  `ISRT_ASSERT_NEXT(a_full_goes_flush, (state_r == ST_IDLE) && in_valid && sts.full, state_r == ST_FL_RD, "full store did not start overflow flush")
  `ISRT_ASSERT_NOW(a_flush_no_input, (state_r == ST_FL_RD) || (state_r == ST_FL_WAIT), in_stall, "input taken during flush")
  `ISRT_ASSERT_NEXT(a_read_then_load, state_r == ST_FL_RD, state_r == ST_FL_LD, "flush read not followed by load")

endmodule

/* src/isrt_dp.sv */
// Insertion sorter datapath: sorted store, pointers, count and output register.
module isrt_dp #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  isrt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output isrt_pkg::out_item_t  out_data,
  input  isrt_pkg::isrt_cmd_t  cmd,
  output isrt_pkg::isrt_sts_t  sts
);
  import isrt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]   store_mem [DEPTH];
  logic [31:0]   rdata_r;
  logic [AW-1:0] rd_addr;
  logic [31:0]   wdata;
  logic          we;

  logic [31:0]   v_r;
  logic          last_r;
  logic [AW-1:0] p_r;
  logic [AW-1:0] k_r;
  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic          out_valid_r;
  out_item_t     out_r;

  // k_inc walks ahead of the read, p-2 is the next compare after a shift
  always_comb begin
    if (cmd.rd_k) begin
      rd_addr = k_r;
    end else if (cmd.shift) begin
      rd_addr = p_r - AW'(2);
    end else begin
      rd_addr = p_r - AW'(1);
    end
  end

  assign we    = cmd.shift | cmd.wr_v;
  assign wdata = cmd.shift ? rdata_r : v_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[p_r] <= wdata;
    end
    rdata_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      v_r    <= in_data.value;
      last_r <= in_data.last;
      p_r    <= count_r[AW-1:0];
    end else if (cmd.shift) begin
      p_r <= p_r - AW'(1);
    end
    if (cmd.fl_start) begin
      k_r   <= '0;
      ovf_r <= cmd.fl_ovf;
    end else if (cmd.k_inc) begin
      k_r <= k_r + AW'(1);
    end
    if (cmd.ld_out) begin
      out_r.value_res <= rdata_r;
      out_r.last_res  <= sts.k_last;
      out_r.overflow  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        count_r <= '0;
      end else if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.full      = (count_r == CW'(DEPTH));
    sts.p_zero    = (p_r == '0);
    sts.p_one     = (p_r == AW'(1));
    sts.less      = ($signed(v_r) < $signed(rdata_r));
    sts.k_last    = ((CW'(k_r) + CW'(1)) == count_r);
    sts.out_taken = out_valid_r & ~out_stall;
    sts.last_held = last_r;
  end

`include "insertion_sorter_macros.svh"

  `ISRT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "element count beyond depth")
  `ISRT_ASSERT_NOW(a_no_overwrite, cmd.ld_out, !out_valid_r, "output register overwritten")
  `ISRT_ASSERT_NOW(a_no_inc_full, cmd.cnt_inc, !sts.full, "insert into full store")
  `ISRT_ASSERT_NOW(a_no_shift_p0, cmd.shift, !sts.p_zero, "shift below entry zero")

endmodule

/* src/insertion_sorter.sv */
// Insertion sorter: accepts one signed value per item into a sorted store of
// DEPTH entries held in a single memory, one write and one registered read per
// cycle. Each item is inserted by shifting every stored entry greater than it
// up one place, one entry after another, as the memory has a single write port.
// After the item marked last, or an item that finds the store full (dropped,
// results flagged overflow), the block emits all stored values in ascending
// order, equal values in arrival order, reading each next value only once the
// previous result has been taken, and accepts no item until the final result
// (last_res set) has been taken. No clearing pass follows reset.
module insertion_sorter #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  isrt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output isrt_pkg::out_item_t out_data
);
  import isrt_pkg::*;

  isrt_cmd_t cmd;
  isrt_sts_t sts;

  isrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  isrt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* dv/tb.sv */
// Self-checking testbench for the insertion sorter: directed and random sets.
`timescale 1ns / 1ps

module tb;
  import isrt_pkg::*;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 260;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;
  localparam int LIMIT_CYCLES = 1000000;

  class sort_scoreboard;
    logic signed [31:0] sorted_model[$];
    out_item_t expected_results[$];
    int unsigned errors;
    int store_depth;

    function new(int d);
      store_depth = d;
      errors = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task emit_sorted(logic ovf);
      out_item_t r;
      for (int k = 0; k < sorted_model.size(); k++) begin
        r.value_res = sorted_model[k];
        r.last_res = (k == sorted_model.size() - 1);
        r.overflow = ovf;
        expected_results.push_back(r);
      end
      sorted_model.delete();
    endtask

    task note_item(in_item_t it);
      int p;
      // a full store drops the item and flushes with overflow
      if (sorted_model.size() >= store_depth) begin
        emit_sorted(1'b1);
      end else begin
        p = sorted_model.size();
        while (p > 0 && it.value < sorted_model[p-1]) p--;
        sorted_model.insert(p, it.value);
        if (it.last) emit_sorted(1'b0);
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result value=%0d last=%0b ovf=%0b",
                         got.value_res, got.last_res, got.overflow));
      end else begin
        want = expected_results.pop_front();
        if (got.value_res !== want.value_res)
          report($sformatf("value_res got %0d want %0d", got.value_res, want.value_res));
        if (got.last_res !== want.last_res)
          report($sformatf("last_res got %0b want %0b", got.last_res, want.last_res));
        if (got.overflow !== want.overflow)
          report($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  sort_scoreboard sb = new(DEPTH);

  int unsigned cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  logic signed [31:0] prev_value = '0;

  insertion_sorter #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // check results before noting new items so a stray result cannot match them
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_item(in_data);
    end
  end

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9)) inside
      [0:3]: v = $urandom;
      [4:5]: v = $signed($urandom_range(0, 16)) - 8;
      6: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 32'sh0;
          default: v = -32'sd1;
        endcase
      end
      7: v = 32'sh8000_0000 + $urandom_range(0, 3);
      8: v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
      default: v = prev_value;
    endcase
    prev_value = v;
    return v;
  endfunction

  task automatic offer_value(input logic signed [31:0] v, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_data <= '{value: v, last: is_last};
    in_valid <= 1'b1;
    // hold the item until the block takes it
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_run(input int n, input logic end_last);
    for (int i = 0; i < n; i++)
      offer_value(pick_value(), (i == n - 1) ? end_last : 1'b0);
  endtask

  initial begin : receiver
    int mode;
    int span;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done && out_valid) begin
        // hold off long enough for the sender to back up behind the flush
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 2);
          span = $urandom_range(10, 80);
        end
        span--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  initial begin : stimulus
    int set_no;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single element
    offer_value(32'sh7FFF_FFFF, 1'b1);
    // extremes, duplicates and sign boundary
    offer_value(32'sh7FFF_FFFF, 1'b0);
    offer_value(32'sh8000_0000, 1'b0);
    offer_value(-32'sd1, 1'b0);
    offer_value(32'sh0, 1'b0);
    offer_value(32'sh1, 1'b0);
    offer_value(32'sh8000_0000, 1'b0);
    offer_value(32'sh7FFF_FFFF, 1'b1);
    // descending: every insert shifts the whole store
    offer_value(32'sd40, 1'b0);
    offer_value(32'sd30, 1'b0);
    offer_value(32'sd20, 1'b0);
    offer_value(32'sd10, 1'b0);
    offer_value(-32'sd10, 1'b1);
    // ascending: no shifts
    offer_value(-32'sd3, 1'b0);
    offer_value(-32'sd2, 1'b0);
    offer_value(-32'sd1, 1'b1);
    // alternating bit patterns with equal values
    offer_value(32'shAAAA_AAAA, 1'b0);
    offer_value(32'sh5555_5555, 1'b0);
    offer_value(32'sh5555_5555, 1'b1);

    hold_armed = 1'b1;
    items_sent = 0;
    set_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (set_no)
        // fill the store without last, then overflow on the next item
        2: begin
          send_run(DEPTH, 1'b0);
          offer_value(pick_value(), 1'b0);
        end
        5: send_run(DEPTH, 1'b1);
        8: begin
          send_run(DEPTH, 1'b0);
          offer_value(pick_value(), 1'b1);
        end
        default: send_run(($urandom_range(0, 4) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 8), 1'b1);
      endcase
      set_no++;
    end
    in_valid <= 1'b0;
    // let the final accepted item reach the scoreboard
    @(posedge clk);

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
